### rtl/alist_pkg.sv
// Shared types and constants for the array list table with exchange sort.
// Used by the channel interfaces, the RAM wrapper and the top level.
`timescale 1ns / 1ps

package alist_pkg;

    localparam int CAPACITY = 128;
    localparam int DATA_W   = 32;
    localparam int CMD_W    = 2;
    localparam int POS_W    = 7;
    localparam int STAT_W   = 2;
    localparam int CNT_W    = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_SEARCH = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_SORT   = 2'd3
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE    = 2'd0,
        ST_MISSING = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_LOAD,
        S_PIVOT,
        S_SWEEP,
        S_WRITEBACK,
        S_RESP
    } state_t;

endpackage

### rtl/alist_if.sv
// Valid/ready channel interfaces for commands and responses.
// Depends on alist_pkg for the field widths.
`timescale 1ns / 1ps

interface alist_req_if;
    logic                              valid;
    logic                              ready;
    logic [alist_pkg::CMD_W-1:0]       command;
    logic signed [alist_pkg::DATA_W-1:0] value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

interface alist_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [alist_pkg::POS_W-1:0]   position;
    logic [alist_pkg::STAT_W-1:0]  status;
    logic [alist_pkg::CNT_W-1:0]   entry_count;

    modport source (output valid, output position, output status, output entry_count,
                    input ready);
    modport sink   (input valid, input position, input status, input entry_count,
                    output ready);
endinterface

### rtl/array_list_table_with_sort.sv
// Top level of the packed list table: command sequencer around one RAM, an
// equality compare and a signed greater-than compare. Depends on alist_pkg,
// alist_if and alist_ram. One command is handled at a time; the request
// channel is ready only when idle. Reset clears the entry count; the RAM
// contents are not cleared.
`timescale 1ns / 1ps

module array_list_table_with_sort #(
    parameter int CAPACITY = alist_pkg::CAPACITY
) (
    input  logic               clk,
    input  logic               rst_n,
    alist_req_if.sink          request,
    alist_rsp_if.source        response
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int DW = alist_pkg::DATA_W;

    alist_pkg::state_t  state_reg, state_next;
    alist_pkg::cmd_t    cmd_reg, cmd_next;
    alist_pkg::status_t status_reg, status_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [IW-1:0]      idx_reg, idx_next;
    logic [IW-1:0]      top_reg, top_next;
    logic [IW-1:0]      pos_reg, pos_next;
    logic [DW-1:0]      value_reg, value_next;
    logic [DW-1:0]      pivot_reg, pivot_next;

    logic               ram_we;
    logic [IW-1:0]      ram_waddr;
    logic [DW-1:0]      ram_wdata;
    logic [IW-1:0]      ram_raddr;
    logic [DW-1:0]      ram_rdata;

    logic               req_fire;
    alist_pkg::cmd_t    req_cmd;
    logic [CW-1:0]      idx_inc;
    logic [CW-1:0]      idx_inc2;
    logic [CW-1:0]      count_last;
    logic [DW-1:0]      top_sel;
    logic               is_full;
    logic               is_empty;
    logic               sort_skip;
    logic               match;
    logic               greater;
    logic               sweep_end;
    logic               shift_more;
    logic [IW+alist_pkg::POS_W-1:0] pos_wide;
    logic [CW+alist_pkg::CNT_W-1:0] count_wide;

    alist_ram #(
        .WIDTH (DW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req_fire   = request.valid && request.ready;
    assign req_cmd    = alist_pkg::cmd_t'(request.command);
    assign idx_inc    = CW'(idx_reg) + CW'(1);
    assign idx_inc2   = CW'(idx_reg) + CW'(2);
    assign count_last = count_reg - CW'(1);
    assign is_full    = (count_reg == CW'(CAPACITY));
    assign is_empty   = (count_reg == '0);
    assign top_sel    = (request.value > DW'(count_last)) ? DW'(count_last) : request.value;
    assign sort_skip  = request.value[DW-1] || is_empty || (top_sel == '0);
    assign match      = (ram_rdata == value_reg);
    assign greater    = ($signed(ram_rdata) > $signed(pivot_reg));
    assign sweep_end  = (idx_inc == CW'(top_reg));
    assign shift_more = (idx_inc < count_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            alist_pkg::S_IDLE:
            begin
                if (req_fire)
                begin
                    case (req_cmd)
                        alist_pkg::CMD_SEARCH,
                        alist_pkg::CMD_REMOVE:
                            state_next = is_empty ? alist_pkg::S_RESP : alist_pkg::S_SCAN;
                        alist_pkg::CMD_SORT:
                            state_next = sort_skip ? alist_pkg::S_RESP : alist_pkg::S_LOAD;
                        default:
                            state_next = alist_pkg::S_RESP;
                    endcase
                end
            end
            alist_pkg::S_SCAN:
            begin
                if (match)
                begin
                    state_next = (cmd_reg == alist_pkg::CMD_REMOVE) ?
                                 alist_pkg::S_SHIFT : alist_pkg::S_RESP;
                end
                else if (idx_inc == count_reg)
                begin
                    state_next = alist_pkg::S_RESP;
                end
            end
            alist_pkg::S_SHIFT:
            begin
                if (!shift_more)
                begin
                    state_next = alist_pkg::S_RESP;
                end
            end
            alist_pkg::S_LOAD:
                state_next = alist_pkg::S_PIVOT;
            alist_pkg::S_PIVOT:
                state_next = alist_pkg::S_SWEEP;
            alist_pkg::S_SWEEP:
            begin
                if (sweep_end)
                begin
                    state_next = alist_pkg::S_WRITEBACK;
                end
            end
            alist_pkg::S_WRITEBACK:
                state_next = (top_reg == IW'(1)) ? alist_pkg::S_RESP : alist_pkg::S_PIVOT;
            alist_pkg::S_RESP:
            begin
                if (response.ready)
                begin
                    state_next = alist_pkg::S_IDLE;
                end
            end
            default:
                state_next = alist_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_next    = cmd_reg;
        status_next = status_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        top_next    = top_reg;
        pos_next    = pos_reg;
        value_next  = value_reg;
        pivot_next  = pivot_reg;
        case (state_reg)
            alist_pkg::S_IDLE:
            begin
                if (req_fire)
                begin
                    cmd_next    = req_cmd;
                    value_next  = request.value;
                    idx_next    = '0;
                    pos_next    = '0;
                    status_next = alist_pkg::ST_DONE;
                    top_next    = top_sel[IW-1:0];
                    case (req_cmd)
                        alist_pkg::CMD_INSERT:
                        begin
                            if (is_full)
                            begin
                                status_next = alist_pkg::ST_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + CW'(1);
                            end
                        end
                        alist_pkg::CMD_SEARCH,
                        alist_pkg::CMD_REMOVE:
                        begin
                            if (is_empty)
                            begin
                                status_next = alist_pkg::ST_MISSING;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            alist_pkg::S_SCAN:
            begin
                if (match)
                begin
                    pos_next = idx_reg;
                end
                else if (idx_inc == count_reg)
                begin
                    status_next = alist_pkg::ST_MISSING;
                end
                else
                begin
                    idx_next = idx_inc[IW-1:0];
                end
            end
            alist_pkg::S_SHIFT:
            begin
                if (shift_more)
                begin
                    idx_next = idx_inc[IW-1:0];
                end
                else
                begin
                    count_next = count_last;
                end
            end
            alist_pkg::S_PIVOT:
            begin
                pivot_next = ram_rdata;
                idx_next   = '0;
            end
            alist_pkg::S_SWEEP:
            begin
                if (greater)
                begin
                    pivot_next = ram_rdata;
                end
                if (!sweep_end)
                begin
                    idx_next = idx_inc[IW-1:0];
                end
            end
            alist_pkg::S_WRITEBACK:
                top_next = top_reg - IW'(1);
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        ram_we         = 1'b0;
        ram_waddr      = idx_reg;
        ram_wdata      = ram_rdata;
        ram_raddr      = '0;
        request.ready  = (state_reg == alist_pkg::S_IDLE);
        response.valid = (state_reg == alist_pkg::S_RESP);
        case (state_reg)
            alist_pkg::S_IDLE:
            begin
                ram_waddr = count_reg[IW-1:0];
                ram_wdata = request.value;
                ram_we    = req_fire && (req_cmd == alist_pkg::CMD_INSERT) && !is_full;
            end
            alist_pkg::S_SCAN:
                ram_raddr = idx_inc[IW-1:0];
            alist_pkg::S_SHIFT:
            begin
                ram_we    = shift_more;
                ram_raddr = idx_inc2[IW-1:0];
            end
            alist_pkg::S_LOAD:
                ram_raddr = top_reg;
            alist_pkg::S_SWEEP:
            begin
                ram_raddr = idx_inc[IW-1:0];
                ram_we    = greater;
                ram_wdata = pivot_reg;
            end
            alist_pkg::S_WRITEBACK:
            begin
                ram_we    = 1'b1;
                ram_waddr = top_reg;
                ram_wdata = pivot_reg;
                ram_raddr = top_reg - IW'(1);
            end
            default:
            begin
            end
        endcase
    end

    assign pos_wide             = {{alist_pkg::POS_W{1'b0}}, pos_reg};
    assign count_wide           = {{alist_pkg::CNT_W{1'b0}}, count_reg};
    assign response.position    = pos_wide[alist_pkg::POS_W-1:0];
    assign response.status      = status_reg;
    assign response.entry_count = count_wide[alist_pkg::CNT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= alist_pkg::S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        status_reg <= status_next;
        idx_reg    <= idx_next;
        top_reg    <= top_next;
        pos_reg    <= pos_next;
        value_reg  <= value_next;
        pivot_reg  <= pivot_next;
    end

endmodule

### rtl/alist_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on alist_pkg for its default parameters; contents are undefined until written.
`timescale 1ns / 1ps

module alist_ram #(
    parameter int WIDTH = alist_pkg::DATA_W,
    parameter int DEPTH = alist_pkg::CAPACITY
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sim/tb_array_list_table_with_sort.sv
`timescale 1ns / 1ps
// Self-checking testbench for array_list_table_with_sort: a directed command table, then
// random command phases, with each response checked against a pinned expected outcome or a behavioral list model.
// Depends on alist_pkg, the alist_req_if/alist_rsp_if interfaces and the top-level RTL.

module tb_array_list_table_with_sort;
    import alist_pkg::*;

    localparam int ITEM_TARGET  = 1850;
    localparam int CYCLE_LIMIT  = 4000000;
    localparam int DRAIN_CYCLES = 200;
    localparam int HOLD_CYCLES  = 400;
    localparam int BIG_SORTS    = 4;

    typedef struct packed {
        logic [POS_W-1:0] position;
        status_t          status;
        logic [CNT_W-1:0] entry_count;
    } outcome_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [DATA_W-1:0] word;
        logic              pinned;
        outcome_t          want;
    } plan_row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    alist_req_if request_ch ();
    alist_rsp_if response_ch ();

    array_list_table_with_sort dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request_ch),
        .response (response_ch)
    );

    logic signed [DATA_W-1:0] list_mem [CAPACITY];
    int                       list_len = 0;
    outcome_t                 pending_q [$];
    plan_row_t                plan_q [$];
    logic                     cur_pinned = 1'b0;
    outcome_t                 cur_want = '0;
    int                       fail_count = 0;
    int                       items_sent = 0;
    int                       cycle_count = 0;
    int                       burst_left = 0;
    logic                     hold_go = 1'b0;

    always #10 clk = ~clk;

    task automatic apply_command(input cmd_t cmd, input logic signed [DATA_W-1:0] word,
                                 output outcome_t res);
        int                       pos;
        int                       top;
        int                       i;
        int                       t;
        logic                     found;
        logic signed [DATA_W-1:0] tmp;
        pos = 0;
        found = 1'b0;
        res = '0;
        res.status = ST_DONE;
        if (cmd == CMD_SEARCH || cmd == CMD_REMOVE)
        begin
            for (i = 0; i < list_len && !found; i++)
            begin
                if (list_mem[i] == word)
                begin
                    found = 1'b1;
                    pos = i;
                end
            end
        end
        case (cmd)
            CMD_INSERT:
            begin
                if (list_len >= CAPACITY)
                    res.status = ST_FULL;
                else
                begin
                    list_mem[list_len] = word;
                    list_len++;
                end
            end
            CMD_SEARCH:
            begin
                if (!found)
                    res.status = ST_MISSING;
            end
            CMD_REMOVE:
            begin
                if (found)
                begin
                    for (i = pos + 1; i < list_len; i++)
                        list_mem[i - 1] = list_mem[i];
                    list_len--;
                end
                else
                    res.status = ST_MISSING;
            end
            CMD_SORT:
            begin
                if (word >= 0 && list_len > 0)
                begin
                    top = (word > list_len - 1) ? list_len - 1 : int'(word);
                    for (t = top; t >= 1; t--)
                    begin
                        for (i = 0; i < t; i++)
                        begin
                            if (list_mem[i] > list_mem[t])
                            begin
                                tmp = list_mem[t];
                                list_mem[t] = list_mem[i];
                                list_mem[i] = tmp;
                            end
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        res.position = POS_W'(found ? pos : 0);
        res.entry_count = CNT_W'(list_len);
    endtask

    always @(posedge clk)
    begin : watch
        outcome_t got;
        outcome_t want;
        outcome_t pred;
        if (rst_n)
        begin
            if (response_ch.valid && response_ch.ready)
            begin
                got.position = response_ch.position;
                got.status = status_t'(response_ch.status);
                got.entry_count = response_ch.entry_count;
                if (pending_q.size() == 0)
                begin
                    $error("unexpected transfer: position %0d status %0d entry_count %0d",
                           got.position, got.status, got.entry_count);
                    fail_count++;
                end
                else
                begin
                    want = pending_q.pop_front();
                    if (got.position !== want.position)
                    begin
                        $error("position: expected %0d, actual %0d",
                               want.position, got.position);
                        fail_count++;
                    end
                    if (got.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, got.status);
                        fail_count++;
                    end
                    if (got.entry_count !== want.entry_count)
                    begin
                        $error("entry_count: expected %0d, actual %0d",
                               want.entry_count, got.entry_count);
                        fail_count++;
                    end
                end
            end
            if (request_ch.valid && request_ch.ready)
            begin
                apply_command(cmd_t'(request_ch.command), request_ch.value, pred);
                pending_q.push_back(cur_pinned ? cur_want : pred);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // The receiver first holds off for a long stretch once the random part starts,
    // then switches between stall patterns of random duration.
    initial
    begin : sink_side
        int hold_left;
        int mode;
        int mode_left;
        int phase_pos;
        hold_left = HOLD_CYCLES;
        mode = 0;
        mode_left = 0;
        phase_pos = 0;
        response_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_go && hold_left > 0)
            begin
                response_ch.ready = 1'b0;
                hold_left--;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(64, 256);
                    phase_pos = 0;
                end
                mode_left--;
                phase_pos++;
                case (mode)
                    0: response_ch.ready = 1'b1;
                    1: response_ch.ready = 1'($urandom_range(0, 1));
                    2: response_ch.ready = ($urandom_range(0, 3) != 0);
                    default: response_ch.ready = ((phase_pos % 7) < 3);
                endcase
            end
        end
    end

    function automatic logic [DATA_W-1:0] rand_word();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6: return DATA_W'($urandom_range(0, 16)) - DATA_W'(8);
            7: return 32'h7fff_ffff;
            8: return 32'h8000_0000;
            default: return 32'hffff_ffff;
        endcase
    endfunction

    task automatic add_row(input cmd_t cmd, input logic [DATA_W-1:0] word, input logic pinned,
                           input int pos, input status_t st, input int cnt);
        plan_row_t row;
        row.cmd = cmd;
        row.word = word;
        row.pinned = pinned;
        row.want.position = POS_W'(pos);
        row.want.status = st;
        row.want.entry_count = CNT_W'(cnt);
        plan_q.push_back(row);
    endtask

    task automatic start_slot();
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                @(negedge clk);
                request_ch.valid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
    endtask

    task automatic drive_item(input cmd_t cmd, input logic [DATA_W-1:0] word,
                              input logic pinned, input outcome_t want);
        request_ch.valid = 1'b1;
        request_ch.command = cmd;
        request_ch.value = word;
        cur_pinned = pinned;
        cur_want = want;
        items_sent++;
        @(posedge clk);
        while (!request_ch.ready)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        request_ch.valid = 1'b0;
        while (pending_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic run_random();
        int                phase;
        int                target;
        int                plen;
        int                n;
        int                r;
        int                ins_share;
        int                big_left;
        int                forced;
        logic              full_hit;
        cmd_t              cmd;
        logic [DATA_W-1:0] word;
        phase = 0;
        big_left = BIG_SORTS;
        while (items_sent < ITEM_TARGET)
        begin
            r = $urandom_range(0, 99);
            if (phase == 1 || r < 8)
                target = CAPACITY;
            else if (r < 30)
                target = $urandom_range(17, 64);
            else
                target = $urandom_range(1, 16);
            plen = (target == CAPACITY) ? 300 : $urandom_range(40, 120);
            full_hit = 1'b0;
            forced = 0;
            for (n = 0; n < plen && items_sent < ITEM_TARGET; n++)
            begin
                start_slot();
                if (target == CAPACITY && list_len == CAPACITY && !full_hit)
                begin
                    full_hit = 1'b1;
                    forced = 2;
                end
                if (forced == 2)
                begin
                    cmd = CMD_INSERT;
                    word = rand_word();
                    forced = 1;
                end
                else if (forced == 1)
                begin
                    cmd = CMD_SORT;
                    word = 32'h7fff_ffff;
                    if (big_left > 0)
                        big_left--;
                    forced = 0;
                end
                else
                begin
                    ins_share = (list_len >= target) ? 15 : (target == CAPACITY) ? 85 : 45;
                    r = $urandom_range(0, 9);
                    if ($urandom_range(0, 99) < ins_share)
                        cmd = CMD_INSERT;
                    else if (r < 4)
                        cmd = CMD_SEARCH;
                    else if (r < 7)
                        cmd = CMD_REMOVE;
                    else
                        cmd = CMD_SORT;
                    if (cmd == CMD_INSERT)
                        word = rand_word();
                    else if (cmd != CMD_SORT)
                        word = (list_len > 0 && $urandom_range(0, 9) < 7)
                               ? list_mem[$urandom_range(0, list_len - 1)] : rand_word();
                    else
                    begin
                        r = $urandom_range(0, 99);
                        if (r < 10)
                            word = $urandom | 32'h8000_0000;
                        else if (list_len > 64)
                        begin
                            if (big_left > 0 && r < 14)
                            begin
                                word = 32'h7fff_ffff;
                                big_left--;
                            end
                            else
                                word = $urandom_range(0, 16);
                        end
                        else if (r < 25)
                            word = (r < 18) ? 32'h7fff_ffff : ($urandom >> 1);
                        else
                            word = $urandom_range(0, 20);
                    end
                end
                drive_item(cmd, word, 1'b0, '0);
            end
            if ($urandom_range(0, 3) == 0)
                wait_drained();
            phase++;
        end
    endtask

    initial
    begin : stimulus
        request_ch.valid = 1'b0;
        request_ch.command = CMD_INSERT;
        request_ch.value = '0;

        add_row(CMD_SEARCH, 32'd5,         1'b1, 0, ST_MISSING, 0);
        add_row(CMD_REMOVE, 32'd5,         1'b1, 0, ST_MISSING, 0);
        add_row(CMD_SORT,   32'd10,        1'b1, 0, ST_DONE,    0);
        add_row(CMD_INSERT, 32'h7fff_ffff, 1'b1, 0, ST_DONE,    1);
        add_row(CMD_INSERT, 32'h8000_0000, 1'b1, 0, ST_DONE,    2);
        add_row(CMD_INSERT, 32'h0000_0000, 1'b1, 0, ST_DONE,    3);
        add_row(CMD_INSERT, 32'hffff_ffff, 1'b1, 0, ST_DONE,    4);
        add_row(CMD_INSERT, 32'h7fff_ffff, 1'b1, 0, ST_DONE,    5);
        add_row(CMD_SEARCH, 32'h7fff_ffff, 1'b1, 0, ST_DONE,    5);
        add_row(CMD_SEARCH, 32'hffff_ffff, 1'b1, 3, ST_DONE,    5);
        add_row(CMD_SEARCH, 32'h0000_3039, 1'b1, 0, ST_MISSING, 5);
        add_row(CMD_SORT,   32'hffff_ffff, 1'b1, 0, ST_DONE,    5);
        add_row(CMD_SORT,   32'h8000_0000, 1'b1, 0, ST_DONE,    5);
        add_row(CMD_SORT,   32'h7fff_ffff, 1'b1, 0, ST_DONE,    5);
        add_row(CMD_SEARCH, 32'h8000_0000, 1'b0, 0, ST_DONE,    0);
        add_row(CMD_REMOVE, 32'h0000_0000, 1'b0, 0, ST_DONE,    0);
        add_row(CMD_REMOVE, 32'h7fff_ffff, 1'b0, 0, ST_DONE,    0);
        add_row(CMD_SEARCH, 32'h7fff_ffff, 1'b0, 0, ST_DONE,    0);
        add_row(CMD_INSERT, 32'h5555_aaaa, 1'b0, 0, ST_DONE,    0);
        add_row(CMD_INSERT, 32'haaaa_5555, 1'b0, 0, ST_DONE,    0);
        add_row(CMD_SORT,   32'd1,         1'b0, 0, ST_DONE,    0);
        add_row(CMD_SORT,   32'd0,         1'b0, 0, ST_DONE,    0);
        add_row(CMD_SORT,   32'd4,         1'b0, 0, ST_DONE,    0);
        add_row(CMD_REMOVE, 32'h8000_0000, 1'b0, 0, ST_DONE,    0);
        add_row(CMD_SEARCH, 32'haaaa_5555, 1'b0, 0, ST_DONE,    0);

        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        foreach (plan_q[k])
        begin
            start_slot();
            drive_item(plan_q[k].cmd, plan_q[k].word, plan_q[k].pinned, plan_q[k].want);
        end
        wait_drained();

        hold_go = 1'b1;
        run_random();
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
